### rtl/core/sorted_priority_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue core.
// Each macro builds a labelled concurrent assertion on clk, or nothing at all
// when assertions are switched off for the build.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue core and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RECORD   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic        command;
        logic [31:0] customer_tag;
        logic [2:0]  priority_req;
        logic [12:0] amount;
        logic [15:0] turn_number;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_tag;
        logic [2:0]  out_priority;
        logic [12:0] out_amount;
        logic [15:0] out_turn;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [2:0]  prio;
        logic [12:0] amount;
        logic [15:0] turn;
    } rec_t;

    // Per-cycle orders broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic rotate;
    } cell_ctrl_t;

endpackage

### rtl/core/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// An insert's status beat is valid in the next cycle, so inserts can follow back
// to back unless the output stalls. A dump's first record beat passes the state
// register, then the output register; the rest follow one per cycle unless stalled;
// the ring turns QUEUE_DEPTH steps, and the next command is stalled until it is done.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // Width of the record count (holds QUEUE_DEPTH itself) and of the
    // rotation counter (an index into the chain).
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = $clog2(QUEUE_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic [CW-1:0] rot_reg;
    logic [CW-1:0] rot_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;

    logic          out_free;
    logic          accept;
    logic          is_full;
    logic          emit_pending;
    logic          emit;
    logic          advance;
    cell_ctrl_t    cell_ctrl;
    rec_t          new_rec;
    rec_t          cell_rec  [QUEUE_DEPTH];
    logic          cell_keep [QUEUE_DEPTH];

    // The output register frees up in the same cycle that its beat is taken,
    // so a new result can follow back to back.
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != S_IDLE) || !out_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign is_full   = (count_reg == NW'(QUEUE_DEPTH));

    assign new_rec.tag    = cmd.customer_tag;
    assign new_rec.prio   = cmd.priority_req;
    assign new_rec.amount = cmd.amount;
    assign new_rec.turn   = cmd.turn_number;

    // During a dump, the first count_reg steps of the rotation each emit the
    // record sitting in cell zero; those steps wait for the output register.
    // The remaining steps only turn the ring back to its starting order.
    assign emit_pending = (state_reg == S_DUMP) && (NW'(rot_reg) < count_reg);
    assign emit         = emit_pending && out_free;
    assign advance      = (state_reg == S_DUMP) && (!emit_pending || out_free);

    assign cell_ctrl.insert = accept && (cmd.command == CMD_INSERT) && !is_full;
    assign cell_ctrl.rotate = advance;

    // The chain of cells. Cell zero has no left neighbour; it behaves as if
    // that neighbour kept its place, so it takes the new record when it moves.
    // The right end wraps round to cell zero for the dump rotation.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        rec_t prev_rec;
        logic prev_keep;

        if (i == 0)
        begin : g_head
            assign prev_rec  = new_rec;
            assign prev_keep = 1'b1;
        end
        else
        begin : g_body
            assign prev_rec  = cell_rec[i-1];
            assign prev_keep = cell_keep[i-1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .entry_valid (NW'(i) < count_reg),
            .new_rec     (new_rec),
            .prev_rec    (prev_rec),
            .prev_keep   (prev_keep),
            .next_rec    (cell_rec[(i + 1) % QUEUE_DEPTH]),
            .rec         (cell_rec[i]),
            .keep        (cell_keep[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rot_next       = rot_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next              = '0;
                    rsp_next.last         = 1'b1;
                    if (cmd.command == CMD_INSERT)
                    begin
                        if (is_full)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            rsp_next.status = ST_INSERTED;
                            count_next      = count_reg + NW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        // The record beats come from the rotation; nothing
                        // is emitted for the command itself.
                        rsp_valid_next = 1'b0;
                        state_next     = S_DUMP;
                        rot_next       = '0;
                    end
                end
            end
            S_DUMP:
            begin
                if (emit)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = ST_RECORD;
                    rsp_next.out_tag      = cell_rec[0].tag;
                    rsp_next.out_priority = cell_rec[0].prio;
                    rsp_next.out_amount   = cell_rec[0].amount;
                    rsp_next.out_turn     = cell_rec[0].turn;
                    rsp_next.last         = ((NW'(rot_reg) + NW'(1)) == count_reg);
                end
                if (advance)
                begin
                    if (rot_reg == CW'(QUEUE_DEPTH - 1))
                    begin
                        state_next = S_IDLE;
                        rot_next   = '0;
                    end
                    else
                    begin
                        rot_next = rot_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rot_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rot_reg       <= rot_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // The result payload needs no reset; it is qualified by rsp_valid_reg.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count can never pass the depth of the chain.
    `SPQ_ASSERT_ALWAYS(a_count_bound, (!rst_n || count_reg <= NW'(QUEUE_DEPTH)), "count exceeds depth")
    // A rejected insert leaves the table size as it was.
    `SPQ_ASSERT(a_full_holds, (accept && cmd.command == CMD_INSERT && is_full) |=> $stable(count_reg), "full insert changed count")
    // Every beat launched during a dump carries a record.
    `SPQ_ASSERT(a_dump_status, emit |=> (rsp_valid && rsp.status == ST_RECORD), "dump beat without record status")
    // While idle the head of the chain is in priority order.
    `SPQ_ASSERT(a_head_sorted, (state_reg == S_IDLE && count_reg >= NW'(2)) |-> (cell_rec[0].prio <= cell_rec[1].prio), "chain head out of order")

endmodule

### rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a record, takes the new record or its
// left neighbour's on an insert, and its right neighbour's on a rotation.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       entry_valid,
    input  rec_t       new_rec,
    input  rec_t       prev_rec,
    input  logic       prev_keep,
    input  rec_t       next_rec,
    output rec_t       rec,
    output logic       keep
);

    rec_t rec_reg;
    rec_t rec_next;

    // A valid record of lower or equal priority stays where it is.
    assign keep = entry_valid && (rec_reg.prio <= new_rec.prio);
    assign rec  = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.rotate)
        begin
            rec_next = next_rec;
        end
        else if (ctrl.insert && !keep)
        begin
            rec_next = prev_keep ? new_rec : prev_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule
